// ----- hw/rtl/mdio_management_master_top_macros.svh -----
// assertion helpers for the mdio management master
`ifndef MDIO_MANAGEMENT_MASTER_TOP_MACROS_SVH
`define MDIO_MANAGEMENT_MASTER_TOP_MACROS_SVH

// generic clocked assertion with an active-low reset
`define MM_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define MM_ASSERT(lbl, prop, msg) \
  `MM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/mdio_mm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_mm_pkg
// Types and constants shared by the mdio management master.
// ----------------------------------------------------------------------------
package mdio_mm_pkg;

  localparam int unsigned PreambleBitsDef = 32;
  localparam logic [7:0]  HalfPeriodRst   = 8'd50;

  // bit positions inside the address/control register
  localparam int unsigned AddrBusyBit  = 0;
  localparam int unsigned AddrWriteBit = 1;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpRead  = 2'd1,
    OpWrite = 2'd2
  } op_e;

  typedef enum logic {
    SelAddr = 1'b0,
    SelData = 1'b1
  } sel_e;

  typedef struct packed {
    op_e         op;
    sel_e        reg_sel;
    logic [15:0] write_data;
    logic        mdio_in;
  } item_t;

  typedef struct packed {
    logic        busy;
    logic        write_mode;
    logic [3:0]  clock_range;
    logic [4:0]  target_reg;
    logic [4:0]  target_phy;
    logic [15:0] data_holding;
    logic [6:0]  bit_idx;
    logic [7:0]  div_cnt;
    logic        clk_lvl;
    logic [15:0] read_shift;
  } mm_state_t;

  typedef struct packed {
    logic lvl;
    logic drv;
  } line_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        busy_res;
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
  } res_t;

endpackage

// ----- hw/rtl/mdio_management_master_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_management_master_top
// Clause 22 management master behind an address/control and a data register.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata, tuser
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata
//   cfg       in   cfg_valid_i/cfg_ready_o       cfg_data_i (mdc half period)
//
// one item per cycle while the result side does not stall; each item goes from the input
// register to the result register, with all state updated in the single pass between them.
// reset clears the master state and both valid flags, the half period returns to 50 ticks.
// a stalled result holds the result register; the input register still
// takes a new item while the result register is free or drains that cycle.
// ----------------------------------------------------------------------------
module mdio_management_master_top import mdio_mm_pkg::*; #(
  parameter int unsigned PREAMBLE_BITS = PreambleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // write_data[15:0], mdio_in[16], zero fill
  input  logic [2:0]  s_axis_tuser,   // op[1:0], reg_sel[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // read_data[15:0], busy_res[16], mdc[17],
                                      // mdio_out[18], mdio_drive[19], zero fill
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  item_t      itm_q;
  logic       itm_vld_q;
  res_t       out_q;
  logic       out_vld_q;
  logic [7:0] half_q;
  logic       adv;
  res_t       res;

  assign adv           = itm_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~itm_vld_q | adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HalfPeriodRst;
    end else if (cfg_valid_i) begin
      half_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itm_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      itm_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      itm_q.op         <= op_e'(s_axis_tuser[1:0]);
      itm_q.reg_sel    <= sel_e'(s_axis_tuser[2]);
      itm_q.write_data <= s_axis_tdata[15:0];
      itm_q.mdio_in    <= s_axis_tdata[16];
    end
  end

  mdio_mm_core #(
    .PREAMBLE_BITS(PREAMBLE_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(itm_q),
    .adv_i (adv),
    .half_i(half_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_q.mdio_drive, out_q.mdio_out, out_q.mdc,
                          out_q.busy_res, out_q.read_data};

endmodule

// ----- hw/rtl/mdio_mm_line.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_mm_line
// Level and drive of the management data line for the current frame bit.
// ----------------------------------------------------------------------------
module mdio_mm_line import mdio_mm_pkg::*; #(
  parameter int unsigned PREAMBLE_BITS = PreambleBitsDef
) (
  input  mm_state_t st_i,
  output line_t     line_o
);

  localparam logic [6:0] PreLen = 7'(PREAMBLE_BITS);

  logic [6:0] r;

  assign r = st_i.bit_idx - PreLen;

  always_comb begin
    line_o = '0;
    if (st_i.busy) begin
      priority if (st_i.bit_idx < PreLen) begin
        line_o = '{lvl: 1'b1, drv: 1'b1};
      end else if (r < 7'd2) begin
        // start pattern 01
        line_o = '{lvl: r[0], drv: 1'b1};
      end else if (r < 7'd4) begin
        // opcode: read 10, write 01
        line_o = '{lvl: st_i.write_mode ? r[0] : ~r[0], drv: 1'b1};
      end else if (r < 7'd9) begin
        line_o = '{lvl: st_i.target_phy[3'(7'd8 - r)], drv: 1'b1};
      end else if (r < 7'd14) begin
        line_o = '{lvl: st_i.target_reg[3'(7'd13 - r)], drv: 1'b1};
      end else if (r < 7'd16) begin
        // turnaround: released on read, 10 on write
        if (st_i.write_mode) begin
          line_o = '{lvl: (r == 7'd14), drv: 1'b1};
        end
      end else if (r < 7'd32) begin
        if (st_i.write_mode) begin
          line_o = '{lvl: st_i.data_holding[4'(7'd31 - r)], drv: 1'b1};
        end
      end else begin
        line_o = '0;
      end
    end
  end

endmodule

// ----- hw/rtl/mdio_mm_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_mm_core
// Register file, clock divider and frame sequencer; one item per advance.
// ----------------------------------------------------------------------------
module mdio_mm_core import mdio_mm_pkg::*; #(
  parameter int unsigned PREAMBLE_BITS = PreambleBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      item_i,
  input  logic       adv_i,
  input  logic [7:0] half_i,
  output res_t       res_o
);

  localparam logic [6:0] RdStart  = 7'(PREAMBLE_BITS + 16);
  localparam logic [6:0] RdEnd    = 7'(PREAMBLE_BITS + 32);
  localparam logic [6:0] FrameLen = 7'(PREAMBLE_BITS + 32);

  mm_state_t   st_q, st_d;
  logic [15:0] rd;
  logic [7:0]  half;
  logic [7:0]  cnt_inc;
  logic [6:0]  idx_inc;
  line_t       line;

  assign half    = (half_i == 8'd0) ? 8'd1 : half_i;
  assign cnt_inc = st_q.div_cnt + 8'd1;
  assign idx_inc = st_q.bit_idx + 7'd1;

  always_comb begin
    st_d = st_q;
    rd   = '0;
    unique case (item_i.op)
      OpTick: begin
        if (st_q.busy) begin
          if (cnt_inc < half) begin
            st_d.div_cnt = cnt_inc;
          end else begin
            st_d.div_cnt = '0;
            if (!st_q.clk_lvl) begin
              st_d.clk_lvl = 1'b1;
              // rising mdc edge: sample the phy during read data
              if (!st_q.write_mode && st_q.bit_idx >= RdStart && st_q.bit_idx < RdEnd) begin
                st_d.read_shift = {st_q.read_shift[14:0], item_i.mdio_in};
              end
            end else begin
              st_d.clk_lvl = 1'b0;
              if (idx_inc >= FrameLen) begin
                st_d.busy    = 1'b0;
                st_d.bit_idx = '0;
                if (!st_q.write_mode) begin
                  st_d.data_holding = st_q.read_shift;
                end
              end else begin
                st_d.bit_idx = idx_inc;
              end
            end
          end
        end
      end
      OpRead: begin
        if (item_i.reg_sel == SelData) begin
          rd = st_q.data_holding;
        end else begin
          rd = {st_q.target_phy, st_q.target_reg, st_q.clock_range,
                st_q.write_mode, st_q.busy};
        end
      end
      OpWrite: begin
        if (!st_q.busy) begin
          if (item_i.reg_sel == SelData) begin
            st_d.data_holding = item_i.write_data;
          end else begin
            st_d.write_mode  = item_i.write_data[AddrWriteBit];
            st_d.clock_range = item_i.write_data[5:2];
            st_d.target_reg  = item_i.write_data[10:6];
            st_d.target_phy  = item_i.write_data[15:11];
            if (item_i.write_data[AddrBusyBit]) begin
              st_d.busy       = 1'b1;
              st_d.bit_idx    = '0;
              st_d.div_cnt    = '0;
              st_d.clk_lvl    = 1'b0;
              st_d.read_shift = '0;
            end
          end
        end
      end
      default: begin
        st_d = st_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

  // line level follows the state after this item
  mdio_mm_line #(
    .PREAMBLE_BITS(PREAMBLE_BITS)
  ) u_line (
    .st_i  (st_d),
    .line_o(line)
  );

  always_comb begin
    res_o.read_data  = rd;
    res_o.busy_res   = st_d.busy;
    res_o.mdc        = st_d.busy & st_d.clk_lvl;
    res_o.mdio_out   = line.lvl;
    res_o.mdio_drive = line.drv;
  end

endmodule

// ----- hw/rtl/mdio_mm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_mm_sva
// Port-level checks for the mdio management master, bound to the top level.
// ----------------------------------------------------------------------------
`include "mdio_management_master_top_macros.svh"

module mdio_mm_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic stall;
  logic res_busy;
  logic res_mdc;
  logic res_out;
  logic res_drv;

  assign stall    = m_axis_tvalid && !m_axis_tready;
  assign res_busy = m_axis_tdata[16];
  assign res_mdc  = m_axis_tdata[17];
  assign res_out  = m_axis_tdata[18];
  assign res_drv  = m_axis_tdata[19];

  // a stalled result holds
  `MM_ASSERT(a_out_hold, stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed")

  // input side only stalls behind a full result register
  `MM_ASSERT(a_no_idle_stall, !s_axis_tready |-> stall, "input stalled without backpressure")

  // idle master keeps mdc low and the line released
  `MM_ASSERT(a_idle_line, m_axis_tvalid && !res_busy |-> !res_mdc && !res_drv, "idle line active")

  // a released line reads as zero
  `MM_ASSERT(a_release_zero, m_axis_tvalid && !res_drv |-> !res_out, "level set while released")

endmodule

bind mdio_management_master_top mdio_mm_sva u_mdio_mm_sva (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ----- tb/mdio_mm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdio_mm_checker
// Watches the access, result and half-period channels of the mdio management
// master, keeps its own copy of the register file and frame sequencer, and
// compares every result item field by field with the predicted status.
// ----------------------------------------------------------------------------
module mdio_mm_checker import mdio_mm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // write_data[15:0], mdio_in[16], zero fill
  input  logic [2:0]  s_axis_tuser,   // op[1:0], reg_sel[2]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // read_data[15:0], busy_res[16], mdc[17],
                                      // mdio_out[18], mdio_drive[19], zero fill
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned FrameBits = (PreambleBitsDef + 32) % 128;

  mm_state_t   mgmt_q;
  logic [7:0]  half_period_q;
  res_t        status_expect_q[$];
  res_t        want_res;

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $time);
    fail_count_o++;
  endtask

  // level and enable of the data line for the current frame bit
  function automatic line_t frame_line(mm_state_t s);
    line_t ln;
    int    r;
    ln = '0;
    if (!s.busy) return ln;
    if (s.bit_idx < PreambleBitsDef) begin
      ln.lvl = 1'b1;
      ln.drv = 1'b1;
    end else begin
      r = int'(s.bit_idx) - int'(PreambleBitsDef);
      if (r < 2) begin
        ln.lvl = r[0];
        ln.drv = 1'b1;
      end else if (r < 4) begin
        ln.lvl = s.write_mode ? (r == 3) : (r == 2);
        ln.drv = 1'b1;
      end else if (r < 9) begin
        ln.lvl = s.target_phy[8 - r];
        ln.drv = 1'b1;
      end else if (r < 14) begin
        ln.lvl = s.target_reg[13 - r];
        ln.drv = 1'b1;
      end else if (r < 16) begin
        // read turnaround leaves the line to the phy
        if (s.write_mode) begin
          ln.lvl = (r == 14);
          ln.drv = 1'b1;
        end
      end else if (r < 32) begin
        if (s.write_mode) begin
          ln.lvl = s.data_holding[31 - r];
          ln.drv = 1'b1;
        end
      end
    end
    return ln;
  endfunction

  function automatic void advance_mdc(logic din);
    logic [7:0] h;
    h = (half_period_q == 8'd0) ? 8'd1 : half_period_q;
    if (!mgmt_q.busy) return;
    mgmt_q.div_cnt = mgmt_q.div_cnt + 8'd1;
    if (mgmt_q.div_cnt < h) return;
    mgmt_q.div_cnt = 8'd0;
    if (!mgmt_q.clk_lvl) begin
      mgmt_q.clk_lvl = 1'b1;
      // read data is captured on rising mdc during the data phase
      if (!mgmt_q.write_mode && mgmt_q.bit_idx >= PreambleBitsDef + 16 &&
          mgmt_q.bit_idx < PreambleBitsDef + 32) begin
        mgmt_q.read_shift = {mgmt_q.read_shift[14:0], din};
      end
    end else begin
      mgmt_q.clk_lvl = 1'b0;
      mgmt_q.bit_idx = mgmt_q.bit_idx + 7'd1;
      if (mgmt_q.bit_idx >= FrameBits) begin
        mgmt_q.busy    = 1'b0;
        mgmt_q.bit_idx = '0;
        if (!mgmt_q.write_mode) mgmt_q.data_holding = mgmt_q.read_shift;
      end
    end
  endfunction

  function automatic res_t predict_mgmt_access(logic [1:0] op, logic sel,
                                               logic [15:0] wd, logic din);
    res_t  r;
    line_t ln;
    r = '0;
    case (op)
      OpTick: advance_mdc(din);
      OpRead: begin
        if (sel == SelData) r.read_data = mgmt_q.data_holding;
        else r.read_data = {mgmt_q.target_phy, mgmt_q.target_reg, mgmt_q.clock_range,
                            mgmt_q.write_mode, mgmt_q.busy};
      end
      OpWrite: begin
        if (!mgmt_q.busy) begin
          if (sel == SelData) begin
            mgmt_q.data_holding = wd;
          end else begin
            mgmt_q.write_mode  = wd[AddrWriteBit];
            mgmt_q.clock_range = wd[5:2];
            mgmt_q.target_reg  = wd[10:6];
            mgmt_q.target_phy  = wd[15:11];
            if (wd[AddrBusyBit]) begin
              mgmt_q.busy       = 1'b1;
              mgmt_q.bit_idx    = '0;
              mgmt_q.div_cnt    = '0;
              mgmt_q.clk_lvl    = 1'b0;
              mgmt_q.read_shift = '0;
            end
          end
        end
      end
      default: ;
    endcase
    ln           = frame_line(mgmt_q);
    r.busy_res   = mgmt_q.busy;
    r.mdc        = mgmt_q.busy & mgmt_q.clk_lvl;
    r.mdio_out   = ln.lvl;
    r.mdio_drive = ln.drv;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mgmt_q        = '0;
      half_period_q = HalfPeriodRst;
      status_expect_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_expect_q.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata[15:0], 16'h0000);
        end else begin
          want_res = status_expect_q.pop_front();
          if (m_axis_tdata[15:0] !== want_res.read_data)
            report_mismatch("read_data", m_axis_tdata[15:0], want_res.read_data);
          if (m_axis_tdata[16] !== want_res.busy_res)
            report_mismatch("busy_res", m_axis_tdata[16], want_res.busy_res);
          if (m_axis_tdata[17] !== want_res.mdc)
            report_mismatch("mdc", m_axis_tdata[17], want_res.mdc);
          if (m_axis_tdata[18] !== want_res.mdio_out)
            report_mismatch("mdio_out", m_axis_tdata[18], want_res.mdio_out);
          if (m_axis_tdata[19] !== want_res.mdio_drive)
            report_mismatch("mdio_drive", m_axis_tdata[19], want_res.mdio_drive);
        end
      end
      if (cfg_valid_i && cfg_ready_o) half_period_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        status_expect_q.push_back(predict_mgmt_access(s_axis_tuser[1:0], s_axis_tuser[2],
                                                      s_axis_tdata[15:0], s_axis_tdata[16]));
      end
      pending_o = status_expect_q.size();
    end
  end

endmodule

// ----- tb/tb_mdio_management_master_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mdio_management_master_top
// Drives register accesses and clock ticks into the mdio management master: a
// directed pass over the register fields, busy handling and a full write frame,
// then random frames with random phy data at half periods 1 and 0, with random
// backpressure on both sides bar the last run. The checker predicts every result.
// ----------------------------------------------------------------------------
module tb_mdio_management_master_top;
  import mdio_mm_pkg::*;

  localparam logic [1:0]  OpRsvd      = 2'd3;
  localparam int unsigned FrameHalves = 2 * (PreambleBitsDef + 32);
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned HoldOffLen  = 300;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 45;
  int unsigned hold_off_reqs = 0;
  int unsigned hold_off_done = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned half_now      = HalfPeriodRst;

  always #4 clk_i = ~clk_i;

  mdio_management_master_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  mdio_mm_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending_results)
  );

  // result side: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_off_done < hold_off_reqs) begin
      m_axis_tready <= 1'b0;
      hold_off_done <= hold_off_done + 1;
      hold_left     <= HoldOffLen;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_access(logic [1:0] op, logic sel, logic [15:0] wd, logic din);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, din, wd};
    s_axis_tuser  <= {sel, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_access();
    send_access(2'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic send_ticks(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_access(OpTick, 1'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
  endtask

  task automatic set_half_period(logic [7:0] value);
    wait_all_results();
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    half_now = value;
  endtask

  function automatic int unsigned ticks_per_half();
    return (half_now == 0) ? 1 : half_now;
  endfunction

  // mostly complete frames with random content, some stray accesses in between;
  // a frame started by a stray address write is run out by the next frame's ticks
  task automatic run_mgmt_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned ticks;
    logic [15:0] addr;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(1) == 1) begin
          send_access(OpWrite, SelData, 16'($urandom), 1'($urandom));
          sent++;
        end
        addr = 16'($urandom);
        addr[AddrBusyBit] = 1'b1;
        send_access(OpWrite, SelAddr, addr, 1'($urandom));
        ticks = FrameHalves * ticks_per_half() + $urandom_range(0, 6);
        for (int unsigned i = 0; i < ticks; i++) begin
          if ($urandom_range(99) < 8) send_random_access();
          else send_access(OpTick, 1'($urandom), 16'($urandom), 1'($urandom));
        end
        send_access(OpRead, SelData, 16'($urandom), 1'($urandom));
        send_access(OpRead, SelAddr, 16'($urandom), 1'($urandom));
        sent += ticks + 3;
        if ($urandom_range(99) < 15) wait_all_results();
      end else begin
        send_random_access();
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_access(OpRead, SelAddr, 16'h0000, 1'b0);
    send_access(OpRead, SelData, 16'hFFFF, 1'b1);
    send_access(OpRsvd, SelData, 16'hFFFF, 1'b1);
    send_access(OpRsvd, SelAddr, 16'hFFFF, 1'b0);
    send_access(OpTick, SelAddr, 16'h0000, 1'b1);   // tick while idle does nothing
    send_access(OpWrite, SelData, 16'hFFFF, 1'b0);
    send_access(OpRead, SelData, 16'h0000, 1'b0);
    send_access(OpWrite, SelAddr, 16'hFFFE, 1'b1);  // all fields set, busy bit clear
    send_access(OpRead, SelAddr, 16'h0000, 1'b0);
    send_access(OpWrite, SelAddr, 16'h0000, 1'b0);
    send_access(OpRead, SelAddr, 16'hFFFF, 1'b1);
    send_access(OpWrite, SelData, 16'h0000, 1'b1);
    send_access(OpRead, SelData, 16'hFFFF, 1'b0);
    send_access(OpWrite, SelData, 16'hA5C3, 1'b0);
    // write frame: phy 31, register 0, range 15
    send_access(OpWrite, SelAddr, 16'hF83F, 1'b0);
    send_access(OpRead, SelAddr, 16'h0000, 1'b1);
    send_access(OpWrite, SelData, 16'h1234, 1'b0);  // ignored while busy
    send_access(OpWrite, SelAddr, 16'h0000, 1'b1);  // ignored while busy
    send_access(OpRead, SelData, 16'h0000, 1'b0);
    send_access(OpRead, SelAddr, 16'h0000, 1'b0);
    send_access(OpRsvd, SelAddr, 16'h0001, 1'b1);
    // first mdc rise on the reset half period, then a fall on the slowest one
    send_ticks(55);
    set_half_period(8'd255);
    send_ticks(260);
    // rest of the frame at one tick per half
    set_half_period(8'd1);
    send_ticks(FrameHalves * ticks_per_half());
    send_access(OpRead, SelData, 16'h0000, 1'b0);
    send_access(OpRead, SelAddr, 16'h0000, 1'b0);

    run_mgmt_traffic(100);

    send_idle_pct <= 45;
    recv_idle_pct <= 34;
    set_half_period(8'd0);
    hold_off_reqs <= hold_off_reqs + 1;
    run_mgmt_traffic(100);

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    set_half_period(8'd1);
    run_mgmt_traffic(100);

    wait_all_results();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
